/* src/sle_pkg.sv */
// shared types, constants and codes for the sorted list engine
package sle_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int POS_W    = 6;
  localparam int OCC_W    = 7;
  localparam int SEL_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

  // operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_GET    = 2'd2;
  localparam logic [1:0] OP_SEARCH = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } in_beat_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] data_out;
    logic                    found;
    logic [1:0]              status;
    logic [OCC_W-1:0]        occupancy;
  } out_beat_t;

  // command broadcast to every cell
  typedef struct packed {
    logic                    ins;
    logic                    pop;
    logic signed [VAL_W-1:0] key;
    logic [SEL_W-1:0]        pos;
  } cell_cmd_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic                    valid;
    logic                    lt;
    logic signed [VAL_W-1:0] value;
  } cell_link_t;

  // row status seen by the top level
  typedef struct packed {
    logic                    found;
    logic                    head_valid;
    logic signed [VAL_W-1:0] head_value;
    logic signed [VAL_W-1:0] rd_data;
  } chain_stat_t;

endpackage

/* src/sle_cell.sv */
// one slot of the sorted row: holds a value and shifts with its neighbors
module sle_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  sle_pkg::cell_cmd_t      cmd,
  input  logic [sle_pkg::SEL_W-1:0] cell_idx,
  input  sle_pkg::cell_link_t     left,
  input  sle_pkg::cell_link_t     right,
  output sle_pkg::cell_link_t     self,
  output logic                    hit,
  output logic signed [sle_pkg::VAL_W-1:0] rd_data
);

  logic                              valid_r, valid_nxt;
  logic signed [sle_pkg::VAL_W-1:0]  value_r, value_nxt;
  logic                              lt;

  assign lt = valid_r && (value_r < cmd.key);

  assign self.valid = valid_r;
  assign self.lt    = lt;
  assign self.value = value_r;

  assign hit     = valid_r && (value_r == cmd.key);
  assign rd_data = (valid_r && (cmd.pos == cell_idx)) ? value_r : '0;

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    priority if (cmd.ins) begin
      if (!lt) begin
        if (left.lt) begin
          valid_nxt = 1'b1;
          value_nxt = cmd.key;
        end else begin
          valid_nxt = left.valid;
          value_nxt = left.value;
        end
      end
    end else if (cmd.pop) begin
      valid_nxt = right.valid;
      value_nxt = right.value;
    end else begin
      // idle: hold
      valid_nxt = valid_r;
      value_nxt = value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

/* src/sle_chain.sv */
// row of cells with the search and read reductions
module sle_chain (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sle_pkg::cell_cmd_t    cmd,
  output sle_pkg::chain_stat_t  stat
);

  localparam int N = sle_pkg::CAPACITY;

  sle_pkg::cell_link_t              links [N];
  logic                             hits  [N];
  logic signed [sle_pkg::VAL_W-1:0] rds   [N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    sle_pkg::cell_link_t left_in, right_in;

    if (i == 0) begin : g_first
      // head always takes the key when it is not below it
      assign left_in = '{valid: 1'b1, lt: 1'b1, value: '0};
    end else begin : g_mid_l
      assign left_in = links[i-1];
    end

    if (i == N - 1) begin : g_last
      assign right_in = '{valid: 1'b0, lt: 1'b0, value: '0};
    end else begin : g_mid_r
      assign right_in = links[i+1];
    end

    sle_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .cell_idx (sle_pkg::SEL_W'(i)),
      .left     (left_in),
      .right    (right_in),
      .self     (links[i]),
      .hit      (hits[i]),
      .rd_data  (rds[i])
    );
  end

  always_comb begin
    stat.found      = 1'b0;
    stat.rd_data    = '0;
    stat.head_valid = links[0].valid;
    stat.head_value = links[0].value;
    for (int k = 0; k < N; k++) begin
      stat.found   = stat.found | hits[k];
      stat.rd_data = stat.rd_data | rds[k];
    end
  end

endmodule

/* src/sorted_list_engine_unit.sv */
// top level of the sorted list engine: a sorted priority queue in a row of cells
//
// input channel: in_valid / in_stall / in_data carry one operation per beat
// (insert, pop smallest, get by rank, search). output channel: out_valid /
// out_stall / out_data return exactly one result beat per input beat, in order,
// holding the read or popped value, the search flag, a status code and the
// occupancy after the operation.
// each cell holds one value; on insert every cell compares the key with its own
// value and either keeps, takes the key, or takes its left neighbor's value, and
// on pop every cell takes its right neighbor's value, so the whole row updates
// in the same cycle. search and get are or-reductions across the row.
// a result shows on out_valid in the cycle after its beat is accepted.
// throughput: one beat per cycle while the receiver does not stall.
// when the receiver stalls with a result waiting, in_stall rises and the block
// holds its result and takes no new beat until the result is taken.
// reset empties the store at once (every cell's valid bit clears); no clearing
// pass is needed, and the first beat may follow reset directly.
module sorted_list_engine_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sle_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sle_pkg::out_beat_t out_data
);

  logic [sle_pkg::CNT_W-1:0] count_r, count_nxt;
  logic                      out_valid_r;
  sle_pkg::out_beat_t        out_beat_r, beat_nxt;
  sle_pkg::cell_cmd_t        cmd;
  sle_pkg::chain_stat_t      stat;
  logic                      accept;
  logic                      empty;
  logic                      full;

  // a beat is taken whenever the output register is free or being drained
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign empty = (count_r == '0);
  assign full  = (count_r == sle_pkg::CNT_W'(sle_pkg::CAPACITY));

  // broadcast to the row
  assign cmd.ins = accept && (in_data.op == sle_pkg::OP_INSERT) && !full;
  assign cmd.pop = accept && (in_data.op == sle_pkg::OP_POP) && !empty;
  assign cmd.key = in_data.value;
  assign cmd.pos = sle_pkg::SEL_W'(in_data.position);

  sle_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .stat  (stat)
  );

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + sle_pkg::CNT_W'(1);
    end else if (cmd.pop) begin
      count_nxt = count_r - sle_pkg::CNT_W'(1);
    end
  end

  // result is formed from the row before it updates
  always_comb begin
    beat_nxt.data_out  = '0;
    beat_nxt.found     = 1'b0;
    beat_nxt.status    = sle_pkg::ST_OK;
    beat_nxt.occupancy = sle_pkg::OCC_W'(count_nxt);
    unique case (in_data.op)
      sle_pkg::OP_INSERT: begin
        if (full) begin
          beat_nxt.status = sle_pkg::ST_FULL;
        end
      end
      sle_pkg::OP_POP: begin
        if (empty) begin
          beat_nxt.status = sle_pkg::ST_EMPTY;
        end else begin
          beat_nxt.data_out = stat.head_value;
        end
      end
      sle_pkg::OP_GET: begin
        // empty check comes before the range check
        if (empty) begin
          beat_nxt.status = sle_pkg::ST_EMPTY;
        end else if (sle_pkg::SEL_W'(in_data.position) >= sle_pkg::SEL_W'(count_r)) begin
          beat_nxt.status = sle_pkg::ST_RANGE;
        end else begin
          beat_nxt.data_out = stat.rd_data;
        end
      end
      sle_pkg::OP_SEARCH: begin
        beat_nxt.found = stat.found;
      end
      default: begin
        beat_nxt.status = sle_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      out_beat_r <= beat_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_beat_r;

  // occupancy never runs past the store size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= sle_pkg::CNT_W'(sle_pkg::CAPACITY))
    else $error("entry count above capacity");

  // the head cell holds a value exactly when the store is not empty
  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    stat.head_valid == (count_r != '0))
    else $error("head cell validity disagrees with entry count");

  // a successful pop shrinks the store by one
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |=> count_r == $past(count_r) - sle_pkg::CNT_W'(1))
    else $error("pop did not decrement entry count");

  // a full report only ever comes with a full store
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_beat_r.status == sle_pkg::ST_FULL)
      |-> out_beat_r.occupancy == sle_pkg::OCC_W'(sle_pkg::CAPACITY))
    else $error("full status with store not full");

endmodule

/* dv/sorted_list_checker.sv */
// result checker for the sorted list engine: predicts every beat and compares results
`timescale 1ns / 1ps

module sorted_list_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  sle_pkg::in_beat_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  sle_pkg::out_beat_t out_data,
  output int                 fail_count,
  output int                 results_owed
);

  // ascending copy of the store
  logic signed [sle_pkg::VAL_W-1:0] shadow_list[$];
  sle_pkg::out_beat_t               expected_results[$];

  function automatic sle_pkg::out_beat_t apply_op(input sle_pkg::in_beat_t b);
    sle_pkg::out_beat_t r;
    int                 at;
    r = '0;
    case (b.op)
      sle_pkg::OP_INSERT: begin
        if (shadow_list.size() >= sle_pkg::CAPACITY) begin
          r.status = sle_pkg::ST_FULL;
        end else begin
          // lands ahead of any equal values
          at = 0;
          while (at < shadow_list.size() && shadow_list[at] < b.value) at++;
          shadow_list.insert(at, b.value);
        end
      end
      sle_pkg::OP_POP: begin
        if (shadow_list.size() == 0) begin
          r.status = sle_pkg::ST_EMPTY;
        end else begin
          r.data_out = shadow_list.pop_front();
        end
      end
      sle_pkg::OP_GET: begin
        if (shadow_list.size() == 0) begin
          r.status = sle_pkg::ST_EMPTY;
        end else if (int'(b.position) >= shadow_list.size()) begin
          r.status = sle_pkg::ST_RANGE;
        end else begin
          r.data_out = shadow_list[b.position];
        end
      end
      default: begin
        for (int i = 0; i < shadow_list.size(); i++) begin
          if (shadow_list[i] == b.value) r.found = 1'b1;
        end
      end
    endcase
    r.occupancy = sle_pkg::OCC_W'(shadow_list.size());
    return r;
  endfunction

  task automatic check_result(input sle_pkg::out_beat_t got);
    sle_pkg::out_beat_t want;
    if (expected_results.size() == 0) begin
      $error("result beat with no operation outstanding: %p", got);
      fail_count++;
    end else begin
      want = expected_results.pop_front();
      if (got.data_out !== want.data_out) begin
        $error("data_out: expected %0d, got %0d", want.data_out, got.data_out);
        fail_count++;
      end
      if (got.found !== want.found) begin
        $error("found: expected %0b, got %0b", want.found, got.found);
        fail_count++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        fail_count++;
      end
      if (got.occupancy !== want.occupancy) begin
        $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_list.delete();
      expected_results.delete();
      results_owed <= 0;
    end else begin
      // a result leaving now belongs to an older beat than one entering now
      if (out_valid && !out_stall) check_result(out_data);
      if (in_valid && !in_stall) expected_results.push_back(apply_op(in_data));
      results_owed <= expected_results.size();
    end
  end

endmodule

/* dv/sorted_list_engine_unit_test.sv */
// testbench top for the sorted list engine: stimulus, idling phases and verdict
`timescale 1ns / 1ps

module sorted_list_engine_unit_test;

  localparam int PHASE_ITEMS = 90;  // beats in the first mixed run of a phase, half in the second
  localparam int BURST_LEN   = sle_pkg::CAPACITY + 4;  // enough to hit full or empty from anywhere

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  sle_pkg::in_beat_t  in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  sle_pkg::out_beat_t out_data;

  int fail_count;
  int results_owed;

  // percent of cycles that each side idles or stalls
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  sorted_list_engine_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  sorted_list_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back-pressure, drawn fresh every cycle and independent of out_valid
  always @(posedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // one beat: optional idle cycles first, then hold the payload until it is taken
  task automatic send_beat(input logic [1:0] op,
                           input logic signed [sle_pkg::VAL_W-1:0] value,
                           input logic [sle_pkg::POS_W-1:0] pos);
    sle_pkg::in_beat_t b;
    b.op       = op;
    b.value    = value;
    b.position = pos;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // sender stays quiet until every outstanding result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  // mix of full-range values, a small pool that yields duplicates and search
  // hits, and the signed extremes with their neighbors
  function automatic logic signed [sle_pkg::VAL_W-1:0] pick_value();
    logic signed [sle_pkg::VAL_W-1:0] v;
    case ($urandom_range(3))
      0: v = $signed($urandom_range(16)) - 8;
      1: begin
        case ($urandom_range(5))
          0: v = 32'sh8000_0000;
          1: v = 32'sh8000_0001;
          2: v = 32'sh7fff_ffff;
          3: v = 32'sh7fff_fffe;
          4: v = -1;
          default: v = 0;
        endcase
      end
      default: v = $signed($urandom());
    endcase
    return v;
  endfunction

  // ranks mostly near the head so that gets land inside the list as well as past it
  function automatic logic [sle_pkg::POS_W-1:0] pick_pos();
    return $urandom_range(1) ? sle_pkg::POS_W'($urandom_range(63))
                             : sle_pkg::POS_W'($urandom_range(15));
  endfunction

  // mixed traffic in bursts that lean strongly or mildly toward filling, or toward draining
  task automatic mixed_traffic(input int count);
    int       left;
    int       burst;
    int       ins_pct;
    int       r;
    logic [1:0] op;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(20, 60);
      case ($urandom_range(2))
        0: ins_pct = 70;
        1: ins_pct = 35;
        default: ins_pct = 15;
      endcase
      for (int i = 0; i < burst && left > 0; i++) begin
        r = $urandom_range(99);
        if (r < ins_pct) op = sle_pkg::OP_INSERT;
        else begin
          case ($urandom_range(2))
            0: op = sle_pkg::OP_POP;
            1: op = sle_pkg::OP_GET;
            default: op = sle_pkg::OP_SEARCH;
          endcase
        end
        send_beat(op, pick_value(), pick_pos());
        left--;
      end
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    // fill past capacity so the full refusal shows up with random content
    for (int i = 0; i < BURST_LEN; i++) send_beat(sle_pkg::OP_INSERT, pick_value(), pick_pos());
    mixed_traffic(PHASE_ITEMS);
    // drain past empty so pops on an empty store show up too
    for (int i = 0; i < BURST_LEN; i++) send_beat(sle_pkg::OP_POP, pick_value(), pick_pos());
    mixed_traffic(PHASE_ITEMS / 2);
    wait_drained();
  endtask

  initial begin
    // hold synchronous reset, then send the first beat right away
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed part: empty-store errors, extremes, duplicates, ranks and drain
    send_beat(sle_pkg::OP_GET,    0,              6'd0);   // empty wins
    send_beat(sle_pkg::OP_POP,    0,              6'd0);   // pop on empty
    send_beat(sle_pkg::OP_SEARCH, 0,              6'd0);   // search on empty is ok, not found
    send_beat(sle_pkg::OP_GET,    0,              6'd63);  // empty checked before range
    send_beat(sle_pkg::OP_INSERT, 0,              6'd0);
    send_beat(sle_pkg::OP_INSERT, 32'sh7fff_ffff, 6'd0);
    send_beat(sle_pkg::OP_INSERT, 32'sh8000_0000, 6'd0);
    send_beat(sle_pkg::OP_INSERT, 0,              6'd0);   // equal value goes ahead of the old one
    send_beat(sle_pkg::OP_INSERT, -1,             6'd0);
    send_beat(sle_pkg::OP_INSERT, 1,              6'd0);
    send_beat(sle_pkg::OP_SEARCH, 32'sh8000_0000, 6'd0);
    send_beat(sle_pkg::OP_SEARCH, 32'sh7fff_ffff, 6'd0);
    send_beat(sle_pkg::OP_SEARCH, 5,              6'd0);   // miss
    send_beat(sle_pkg::OP_GET,    0,              6'd0);
    send_beat(sle_pkg::OP_GET,    0,              6'd5);   // last occupied rank
    send_beat(sle_pkg::OP_GET,    0,              6'd6);   // one past the end
    send_beat(sle_pkg::OP_GET,    -1,             6'd63);
    send_beat(sle_pkg::OP_POP,    0,              6'd0);
    send_beat(sle_pkg::OP_POP,    0,              6'd0);
    send_beat(sle_pkg::OP_POP,    0,              6'd0);
    send_beat(sle_pkg::OP_SEARCH, 0,              6'd0);   // one of the duplicates is still there
    send_beat(sle_pkg::OP_POP,    0,              6'd0);
    send_beat(sle_pkg::OP_POP,    0,              6'd0);
    send_beat(sle_pkg::OP_POP,    0,              6'd0);
    send_beat(sle_pkg::OP_POP,    0,              6'd0);   // pop on empty again
    wait_drained();

    // random part under each idling pattern
    run_phase(0, 0);
    run_phase(88, 0);
    run_phase(0, 88);
    run_phase(23, 23);

    recv_stall_pct = 0;
    wait_drained();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
